// ===== rtl/obdm01_pkg.sv =====
`default_nettype none

package obdm01_pkg;

    // Field widths
    localparam int CAN_ID_W = 11;
    localparam int LEN_W    = 4;
    localparam int BYTE_W   = 8;
    localparam int Q16_W    = 33;

    // PID table
    localparam int PID_COUNT    = 28;
    localparam int TABLE_SIZE   = 28;
    localparam int SEARCH_COUNT = (PID_COUNT < TABLE_SIZE) ? PID_COUNT : TABLE_SIZE;
    localparam int IDX_W        = $clog2(TABLE_SIZE);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_LOW  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_HIGH = 1'd1;
    localparam logic [CAN_ID_W-1:0]  ID_LOW_RESET  = 11'h7E8;
    localparam logic [CAN_ID_W-1:0]  ID_HIGH_RESET = 11'h7EF;

    // Frame checks
    localparam logic [BYTE_W-1:0] MODE_RESP   = 8'h41;
    localparam logic [LEN_W-1:0]  MIN_LEN     = 4'd3;
    localparam logic [3:0]        PCI_TYPE_SF = 4'h0;
    localparam logic [3:0]        SF_LEN_MIN  = 4'd2;
    localparam logic [3:0]        SF_LEN_MAX  = 4'd7;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Datapath widths
    localparam int RAW_W  = 16;
    localparam int MUL_W  = 7;
    localparam int N_W    = RAW_W + MUL_W;
    localparam int X_W    = 32;
    localparam int SH_W   = 5;
    localparam int H_W    = 7;
    localparam int OFF_W  = 8;
    localparam int NEED_W = 2;
    localparam int D_W    = 8;
    localparam int DSEL_W = 3;

    // Odd divisor left after the power-of-two part is folded into the shift
    localparam logic [DSEL_W-1:0] DSEL_1   = 3'd0;
    localparam logic [DSEL_W-1:0] DSEL_5   = 3'd1;
    localparam logic [DSEL_W-1:0] DSEL_25  = 3'd2;
    localparam logic [DSEL_W-1:0] DSEL_125 = 3'd3;
    localparam logic [DSEL_W-1:0] DSEL_255 = 3'd4;

    typedef struct packed {
        logic [BYTE_W-1:0]       pid;
        logic [NEED_W-1:0]       need;
        logic                    wide;
        logic [MUL_W-1:0]        mul;
        logic [SH_W-1:0]         sh;
        logic [DSEL_W-1:0]       dsel;
        logic [H_W-1:0]          h;
        logic                    add257;
        logic signed [OFF_W-1:0] off;
    } t_rule;

    typedef struct packed {
        logic [BYTE_W-1:0] pid;
        logic [IDX_W-1:0]  idx;
        logic [BYTE_W-1:0] a;
        logic [BYTE_W-1:0] b;
    } t_qentry;

    // value = off*65536 + (add257 ? N*257 : 0) + floor(((N << sh) + h) / d), N = raw*mul
    function automatic t_rule mk_rule(
        input logic [BYTE_W-1:0]       pid,
        input logic [NEED_W-1:0]       need,
        input logic                    wide,
        input logic [MUL_W-1:0]        mul,
        input logic [SH_W-1:0]         sh,
        input logic [DSEL_W-1:0]       dsel,
        input logic [H_W-1:0]          h,
        input logic                    add257,
        input logic signed [OFF_W-1:0] off
    );
        t_rule r;
        r.pid    = pid;
        r.need   = need;
        r.wide   = wide;
        r.mul    = mul;
        r.sh     = sh;
        r.dsel   = dsel;
        r.h      = h;
        r.add257 = add257;
        r.off    = off;
        return r;
    endfunction

    function automatic t_rule get_rule(input logic [IDX_W-1:0] idx);
        t_rule r;
        case (idx)
            5'd0:  r = mk_rule(8'h04, 2'd1, 1'b0, 7'd100, 5'd0,  DSEL_255, 7'd127, 1'b1, 8'sd0);
            5'd1:  r = mk_rule(8'h05, 2'd1, 1'b0, 7'd1,   5'd16, DSEL_1,   7'd0,   1'b0, -8'sd40);
            5'd2:  r = mk_rule(8'h06, 2'd1, 1'b0, 7'd100, 5'd9,  DSEL_1,   7'd0,   1'b0, -8'sd100);
            5'd3:  r = mk_rule(8'h07, 2'd1, 1'b0, 7'd100, 5'd9,  DSEL_1,   7'd0,   1'b0, -8'sd100);
            5'd4:  r = mk_rule(8'h0A, 2'd1, 1'b0, 7'd3,   5'd16, DSEL_1,   7'd0,   1'b0, 8'sd0);
            5'd5:  r = mk_rule(8'h0B, 2'd1, 1'b0, 7'd1,   5'd16, DSEL_1,   7'd0,   1'b0, 8'sd0);
            5'd6:  r = mk_rule(8'h0C, 2'd2, 1'b1, 7'd1,   5'd14, DSEL_1,   7'd0,   1'b0, 8'sd0);
            5'd7:  r = mk_rule(8'h0D, 2'd1, 1'b0, 7'd1,   5'd16, DSEL_1,   7'd0,   1'b0, 8'sd0);
            5'd8:  r = mk_rule(8'h0E, 2'd1, 1'b0, 7'd1,   5'd15, DSEL_1,   7'd0,   1'b0, -8'sd64);
            5'd9:  r = mk_rule(8'h0F, 2'd1, 1'b0, 7'd1,   5'd16, DSEL_1,   7'd0,   1'b0, -8'sd40);
            5'd10: r = mk_rule(8'h10, 2'd2, 1'b1, 7'd1,   5'd14, DSEL_25,  7'd12,  1'b0, 8'sd0);
            5'd11: r = mk_rule(8'h11, 2'd1, 1'b0, 7'd100, 5'd0,  DSEL_255, 7'd127, 1'b1, 8'sd0);
            5'd12: r = mk_rule(8'h14, 2'd2, 1'b0, 7'd1,   5'd13, DSEL_25,  7'd12,  1'b0, 8'sd0);
            5'd13: r = mk_rule(8'h15, 2'd2, 1'b0, 7'd1,   5'd13, DSEL_25,  7'd12,  1'b0, 8'sd0);
            5'd14: r = mk_rule(8'h1F, 2'd2, 1'b1, 7'd1,   5'd16, DSEL_1,   7'd0,   1'b0, 8'sd0);
            5'd15: r = mk_rule(8'h21, 2'd2, 1'b1, 7'd1,   5'd16, DSEL_1,   7'd0,   1'b0, 8'sd0);
            5'd16: r = mk_rule(8'h2E, 2'd1, 1'b0, 7'd100, 5'd0,  DSEL_255, 7'd127, 1'b1, 8'sd0);
            5'd17: r = mk_rule(8'h2F, 2'd1, 1'b0, 7'd100, 5'd0,  DSEL_255, 7'd127, 1'b1, 8'sd0);
            5'd18: r = mk_rule(8'h33, 2'd1, 1'b0, 7'd1,   5'd16, DSEL_1,   7'd0,   1'b0, 8'sd0);
            5'd19: r = mk_rule(8'h42, 2'd2, 1'b1, 7'd1,   5'd13, DSEL_125, 7'd62,  1'b0, 8'sd0);
            5'd20: r = mk_rule(8'h43, 2'd2, 1'b1, 7'd100, 5'd0,  DSEL_255, 7'd127, 1'b1, 8'sd0);
            5'd21: r = mk_rule(8'h44, 2'd2, 1'b1, 7'd1,   5'd1,  DSEL_1,   7'd0,   1'b0, 8'sd0);
            5'd22: r = mk_rule(8'h45, 2'd1, 1'b0, 7'd100, 5'd0,  DSEL_255, 7'd127, 1'b1, 8'sd0);
            5'd23: r = mk_rule(8'h46, 2'd1, 1'b0, 7'd1,   5'd16, DSEL_1,   7'd0,   1'b0, -8'sd40);
            5'd24: r = mk_rule(8'h49, 2'd1, 1'b0, 7'd100, 5'd0,  DSEL_255, 7'd127, 1'b1, 8'sd0);
            5'd25: r = mk_rule(8'h4C, 2'd1, 1'b0, 7'd100, 5'd0,  DSEL_255, 7'd127, 1'b1, 8'sd0);
            5'd26: r = mk_rule(8'h5C, 2'd1, 1'b0, 7'd1,   5'd16, DSEL_1,   7'd0,   1'b0, -8'sd40);
            5'd27: r = mk_rule(8'h5E, 2'd2, 1'b1, 7'd1,   5'd14, DSEL_5,   7'd2,   1'b0, 8'sd0);
            default: r = mk_rule(8'h00, 2'd3, 1'b0, 7'd0, 5'd0, DSEL_1, 7'd0, 1'b0, 8'sd0);
        endcase
        return r;
    endfunction

    // floor(2^32 / d): with x < 2^32 the estimate is short by at most one
    function automatic logic [X_W-1:0] recip(input logic [DSEL_W-1:0] dsel);
        logic [X_W-1:0] m;
        case (dsel)
            DSEL_5:   m = 32'd858993459;
            DSEL_25:  m = 32'd171798691;
            DSEL_125: m = 32'd34359738;
            DSEL_255: m = 32'd16843009;
            default:  m = 32'd0;
        endcase
        return m;
    endfunction

    function automatic logic [D_W-1:0] divisor(input logic [DSEL_W-1:0] dsel);
        logic [D_W-1:0] d;
        case (dsel)
            DSEL_5:   d = 8'd5;
            DSEL_25:  d = 8'd25;
            DSEL_125: d = 8'd125;
            DSEL_255: d = 8'd255;
            default:  d = 8'd1;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/obdm01_frame_if.sv =====
`default_nettype none

interface obdm01_frame_if;
    logic                                  valid;
    logic                                  ready;
    logic [obdm01_pkg::CAN_ID_W-1:0]       can_id;
    logic [obdm01_pkg::LEN_W-1:0]          frame_length;
    logic [obdm01_pkg::BYTE_W-1:0]         pci_byte;
    logic [obdm01_pkg::BYTE_W-1:0]         mode_byte;
    logic [obdm01_pkg::BYTE_W-1:0]         pid_byte;
    logic [obdm01_pkg::BYTE_W-1:0]         value_a;
    logic [obdm01_pkg::BYTE_W-1:0]         value_b;

    modport source (
        output valid, can_id, frame_length, pci_byte, mode_byte, pid_byte, value_a, value_b,
        input  ready
    );
    modport sink (
        input  valid, can_id, frame_length, pci_byte, mode_byte, pid_byte, value_a, value_b,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/obdm01_result_if.sv =====
`default_nettype none

interface obdm01_result_if;
    logic                                 valid;
    logic                                 ready;
    logic [obdm01_pkg::BYTE_W-1:0]        pid;
    logic signed [obdm01_pkg::Q16_W-1:0]  value_q16;

    modport source (
        output valid, pid, value_q16,
        input  ready
    );
    modport sink (
        input  valid, pid, value_q16,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/obd_mode01_response_decoder_core.sv =====
// OBD-II mode 01 response decoder, top level.
// A frame accepted into the queue passes through the scale stage, the quotient
// stage and the output register, each held while the stage after it is stalled.
// Throughput: one frame per cycle while the output is taken; the 32x32 reciprocal multiply sets the clock.
// Reset (synchronous, active low): window returns to 0x7E8..0x7EF, queue and pipeline empty.
`default_nettype none

module obd_mode01_response_decoder_core (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [obdm01_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [obdm01_pkg::CFG_DATA_W-1:0] i_cfg_data,
    obdm01_frame_if.sink                           i_frame,
    obdm01_result_if.source                        o_result
);

    // Front: check header and window, look up the PID, keep only frames that decode.
    logic                push_valid;
    logic                push_ready;
    obdm01_pkg::t_qentry push_entry;

    // Back side of the queue
    logic                pop_valid;
    logic                pop;
    obdm01_pkg::t_qentry pop_entry;

    obdm01_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_frame      (i_frame),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_entry (push_entry)
    );

    // Short queue: lets the front keep taking frames while the back is stalled
    // on the output. Rejected frames are dropped at the front and never enter.
    obdm01_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_valid),
        .i_push_entry (push_entry),
        .o_not_full   (push_ready),
        .o_pop_valid  (pop_valid),
        .i_pop        (pop),
        .o_pop_entry  (pop_entry)
    );

    // Back: scale by the table's multiplier and shift, divide by the odd part of the
    // divisor through a reciprocal multiply with one-step correction, add the N*257
    // term where the rule asks and the offset, and hold the result in the output register until taken.
    obdm01_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .i_pop_entry (pop_entry),
        .o_pop       (pop),
        .o_result    (o_result)
    );

endmodule

`default_nettype wire

// ===== rtl/obdm01_front.sv =====
`default_nettype none

module obdm01_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [obdm01_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [obdm01_pkg::CFG_DATA_W-1:0] i_cfg_data,
    obdm01_frame_if.sink                           i_frame,
    output logic                                   o_push_valid,
    input  wire logic                              i_push_ready,
    output obdm01_pkg::t_qentry                    o_push_entry
);

    logic [obdm01_pkg::CAN_ID_W-1:0]   r_id_low;
    logic [obdm01_pkg::CAN_ID_W-1:0]   r_id_high;
    logic [obdm01_pkg::SEARCH_COUNT-1:0] hit;
    logic [obdm01_pkg::IDX_W-1:0]      hit_idx;
    logic                              hdr_ok;
    logic [3:0]                        sf_len;
    logic [3:0]                        avail;
    obdm01_pkg::t_rule                 rule;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_low  <= obdm01_pkg::ID_LOW_RESET;
            r_id_high <= obdm01_pkg::ID_HIGH_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                obdm01_pkg::CFG_ID_LOW:  r_id_low  <= i_cfg_data;
                obdm01_pkg::CFG_ID_HIGH: r_id_high <= i_cfg_data;
            endcase
        end
    end

    // Header checks
    always_comb begin
        sf_len = i_frame.pci_byte[3:0];
        avail  = sf_len - obdm01_pkg::SF_LEN_MIN;
        hdr_ok = (i_frame.can_id >= r_id_low) && (i_frame.can_id <= r_id_high)
              && (i_frame.frame_length >= obdm01_pkg::MIN_LEN)
              && (i_frame.pci_byte[7:4] == obdm01_pkg::PCI_TYPE_SF)
              && (sf_len >= obdm01_pkg::SF_LEN_MIN) && (sf_len <= obdm01_pkg::SF_LEN_MAX)
              && (i_frame.mode_byte == obdm01_pkg::MODE_RESP);
    end

    // Match the PID against every table entry at once; PIDs are unique
    always_comb begin
        hit_idx = '0;
        for (int k = 0; k < obdm01_pkg::SEARCH_COUNT; k++) begin
            hit[k] = (obdm01_pkg::get_rule(obdm01_pkg::IDX_W'(k)).pid == i_frame.pid_byte);
            hit_idx = hit_idx | (hit[k] ? obdm01_pkg::IDX_W'(k) : '0);
        end
        rule = obdm01_pkg::get_rule(hit_idx);
    end

    assign i_frame.ready = i_push_ready;

    always_comb begin
        o_push_valid = i_frame.valid && hdr_ok && (|hit)
                    && (avail >= {2'b00, rule.need});
        o_push_entry.pid = i_frame.pid_byte;
        o_push_entry.idx = hit_idx;
        o_push_entry.a   = i_frame.value_a;
        o_push_entry.b   = i_frame.value_b;
    end

endmodule

`default_nettype wire

// ===== rtl/obdm01_queue.sv =====
`default_nettype none

module obdm01_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  obdm01_pkg::t_qentry      i_push_entry,
    output logic                     o_not_full,
    output logic                     o_pop_valid,
    input  wire logic                i_pop,
    output obdm01_pkg::t_qentry      o_pop_entry
);

    localparam int DEPTH = obdm01_pkg::QUEUE_DEPTH;

    obdm01_pkg::t_qentry               r_mem [DEPTH];
    logic [obdm01_pkg::QPTR_W-1:0]     r_wr_ptr;
    logic [obdm01_pkg::QPTR_W-1:0]     r_rd_ptr;
    logic [obdm01_pkg::QCNT_W-1:0]     r_count;
    logic [obdm01_pkg::QCNT_W-1:0]     n_count;
    logic                              do_push;
    logic                              do_pop;

    assign o_not_full  = (r_count != obdm01_pkg::QCNT_W'(DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_entry = r_mem[r_rd_ptr];
    assign do_push     = i_push && o_not_full;
    assign do_pop      = i_pop && o_pop_valid;

    always_comb begin
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == obdm01_pkg::QPTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == obdm01_pkg::QPTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= obdm01_pkg::QCNT_W'(DEPTH))
        else $error("queue count beyond depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_not_full && !do_pop) |=> (r_count == obdm01_pkg::QCNT_W'(DEPTH)))
        else $error("full queue changed without a pop");

    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == obdm01_pkg::QCNT_W'(DEPTH)) |-> (r_wr_ptr == r_rd_ptr))
        else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== rtl/obdm01_back.sv =====
`default_nettype none

module obdm01_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_pop_valid,
    input  obdm01_pkg::t_qentry i_pop_entry,
    output logic                o_pop,
    obdm01_result_if.source     o_result
);

    obdm01_pkg::t_rule rule;
    logic [obdm01_pkg::RAW_W-1:0] raw;
    logic en1;
    logic en2;
    logic en3;

    // Stage 1: scale by the PID's multiplier
    logic                                r_v1;
    logic [obdm01_pkg::BYTE_W-1:0]       r_pid1;
    logic [obdm01_pkg::N_W-1:0]          r_n1;
    logic [obdm01_pkg::SH_W-1:0]         r_sh1;
    logic [obdm01_pkg::H_W-1:0]          r_h1;
    logic [obdm01_pkg::DSEL_W-1:0]       r_dsel1;
    logic                                r_add1;
    logic signed [obdm01_pkg::OFF_W-1:0] r_off1;

    // Stage 2: reciprocal estimate of the quotient
    logic                                r_v2;
    logic [obdm01_pkg::BYTE_W-1:0]       r_pid2;
    logic [obdm01_pkg::X_W-1:0]          r_x2;
    logic [obdm01_pkg::X_W-1:0]          r_q2;
    logic [obdm01_pkg::X_W-1:0]          r_base2;
    logic [obdm01_pkg::DSEL_W-1:0]       r_dsel2;
    logic signed [obdm01_pkg::OFF_W-1:0] r_off2;

    // Output register
    logic                                r_v3;
    logic [obdm01_pkg::BYTE_W-1:0]       r_pid3;
    logic signed [obdm01_pkg::Q16_W-1:0] r_val3;

    logic [obdm01_pkg::X_W-1:0]          x1;
    logic [2*obdm01_pkg::X_W-1:0]        prod2;
    logic [obdm01_pkg::X_W-1:0]          base1;
    logic [obdm01_pkg::X_W+obdm01_pkg::D_W-1:0] qd3;
    logic [obdm01_pkg::X_W-1:0]          rem3;
    logic [obdm01_pkg::X_W-1:0]          q3;
    logic [obdm01_pkg::D_W-1:0]          d3;

    assign en3   = !r_v3 || o_result.ready;
    assign en2   = !r_v2 || en3;
    assign en1   = !r_v1 || en2;
    assign o_pop = i_pop_valid && en1;

    always_comb begin
        rule = obdm01_pkg::get_rule(i_pop_entry.idx);
        raw  = rule.wide ? {i_pop_entry.a, i_pop_entry.b} : {8'h00, i_pop_entry.a};
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_pid1  <= i_pop_entry.pid;
            r_n1    <= {7'b0, raw} * {16'b0, rule.mul};
            r_sh1   <= rule.sh;
            r_h1    <= rule.h;
            r_dsel1 <= rule.dsel;
            r_add1  <= rule.add257;
            r_off1  <= rule.off;
        end
    end

    // Shifted numerator with the rounding half added; N*257 for the 100/255 scale
    always_comb begin
        x1    = obdm01_pkg::X_W'({9'b0, r_n1} << r_sh1) + {25'b0, r_h1};
        base1 = r_add1 ? ({1'b0, r_n1, 8'b0} + {9'b0, r_n1}) : '0;
        prod2 = {32'b0, x1} * {32'b0, obdm01_pkg::recip(r_dsel1)};
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_pid2  <= r_pid1;
            r_x2    <= x1;
            r_q2    <= prod2[2*obdm01_pkg::X_W-1:obdm01_pkg::X_W];
            r_base2 <= base1;
            r_dsel2 <= r_dsel1;
            r_off2  <= r_off1;
        end
    end

    // Correct the estimate by one where the remainder reaches d; d = 1 takes x
    always_comb begin
        d3   = obdm01_pkg::divisor(r_dsel2);
        qd3  = {8'b0, r_q2} * {32'b0, d3};
        rem3 = r_x2 - qd3[obdm01_pkg::X_W-1:0];
        if (r_dsel2 == obdm01_pkg::DSEL_1) begin
            q3 = r_x2;
        end else if (rem3 >= {24'b0, d3}) begin
            q3 = r_q2 + 1'b1;
        end else begin
            q3 = r_q2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_pid3 <= r_pid2;
            r_val3 <= $signed({1'b0, r_base2 + q3})
                    + $signed({{9{r_off2[obdm01_pkg::OFF_W-1]}}, r_off2, 16'b0});
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_pop_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    assign o_result.valid     = r_v3;
    assign o_result.pid       = r_pid3;
    assign o_result.value_q16 = r_val3;

    a_no_pop_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && !o_result.ready) |-> !o_pop)
        else $error("queue popped while pipeline is full and stalled");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && en3) |=> r_v3)
        else $error("item lost between stage 2 and output");

endmodule

`default_nettype wire
